[rtl/pls_pkg.sv]
package pls_pkg;

    // Operation codes carried on the kind port.
    typedef enum logic [2:0] {
        KIND_INS_HEAD = 3'd0,
        KIND_INS_TAIL = 3'd1,
        KIND_INS_POS  = 3'd2,
        KIND_DEL_HEAD = 3'd3,
        KIND_DEL_TAIL = 3'd4,
        KIND_DEL_POS  = 3'd5,
        KIND_READ_POS = 3'd6
    } t_kind;

    // Completion codes reported with every result.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_FULL  = 2'd3
    } t_status;

    localparam int POS_W   = 16;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic             ins;  // open a gap at loc and write the new value there
        logic             del;  // close the gap at loc
        logic             tap;  // the cell at loc drives its value onto the tap bus
        logic [POS_W-1:0] loc;  // target location of the operation
    } t_cell_ctl;

endpackage

[rtl/pls_cell.sv]
module pls_cell
    import pls_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [VALUE_W-1:0] i_new_value,
    input  logic [VALUE_W-1:0] i_left,
    input  logic [VALUE_W-1:0] i_right,
    output logic [VALUE_W-1:0] o_value,
    output logic [VALUE_W-1:0] o_tap
);

    localparam logic [POS_W-1:0] MyIndex = POS_W'(INDEX);

    logic [VALUE_W-1:0] r_value;
    logic               at_loc;
    logic               above_loc;

    assign at_loc    = (MyIndex == i_ctl.loc);
    assign above_loc = (MyIndex > i_ctl.loc);

    // An insert pulls from the lower neighbor, a delete from the upper one.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (above_loc) begin
                r_value <= i_left;
            end else if (at_loc) begin
                r_value <= i_new_value;
            end
        end else if (i_ctl.del && (above_loc || at_loc)) begin
            r_value <= i_right;
        end
    end

    assign o_value = r_value;
    assign o_tap   = (i_ctl.tap && at_loc) ? r_value : '0;

endmodule

[rtl/pls_ctrl.sv]
module pls_ctrl
    import pls_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [2:0]         i_kind,
    input  logic [POS_W-1:0]   i_position,
    input  logic [VALUE_W-1:0] i_tap_value,
    output t_cell_ctl          o_ctl,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [COUNT_W-1:0] o_entry_count,
    output logic [VALUE_W-1:0] o_out_value,
    output logic               o_out_valid
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_done;
    t_status                  r_status;
    logic [COUNT_W-1:0]       r_entry_count;
    logic [VALUE_W-1:0]       r_out_value;
    logic                     r_out_valid;

    t_status                  status;
    logic                     valid;
    t_cell_ctl                ctl;
    logic                     pos_neg;
    logic [POS_W-1:0]         pos_u;
    logic [POS_W-1:0]         cnt_p;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    assign pos_neg = i_position[POS_W-1];
    assign pos_u   = {1'b0, i_position[POS_W-2:0]};
    assign cnt_p   = POS_W'(r_count);

    always_comb begin
        status  = STATUS_OK;
        valid   = 1'b0;
        n_count = r_count;
        ctl     = '0;
        unique case (t_kind'(i_kind)) inside
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_POS: begin
                if (t_kind'(i_kind) == KIND_INS_POS && (pos_neg || pos_u > cnt_p)) begin
                    status = STATUS_RANGE;
                end else if (r_count == CapCount) begin
                    status = STATUS_FULL;
                end else begin
                    ctl.ins = i_accept;
                    ctl.loc = (t_kind'(i_kind) == KIND_INS_HEAD) ? '0 :
                              (t_kind'(i_kind) == KIND_INS_TAIL) ? cnt_p : pos_u;
                    n_count = r_count + 1'b1;
                end
            end
            KIND_DEL_HEAD, KIND_DEL_TAIL, KIND_DEL_POS, KIND_READ_POS: begin
                if (r_count == '0) begin
                    status = STATUS_EMPTY;
                end else if ((t_kind'(i_kind) == KIND_DEL_POS ||
                              t_kind'(i_kind) == KIND_READ_POS) &&
                             (pos_neg || pos_u >= cnt_p)) begin
                    status = STATUS_RANGE;
                end else begin
                    valid   = 1'b1;
                    ctl.tap = 1'b1;
                    ctl.loc = (t_kind'(i_kind) == KIND_DEL_HEAD) ? '0 :
                              (t_kind'(i_kind) == KIND_DEL_TAIL) ? cnt_p - 1'b1 : pos_u;
                    if (t_kind'(i_kind) != KIND_READ_POS) begin
                        ctl.del = i_accept;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign cnt_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_accept;
            if (i_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status      <= status;
            r_entry_count <= cnt_ext[COUNT_W-1:0];
            r_out_value   <= valid ? i_tap_value : '0;
            r_out_valid   <= valid;
        end
    end

    assign o_ctl         = ctl;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_out_value   = r_out_value;
    assign o_out_valid   = r_out_valid;

endmodule

[rtl/positional_list_store_top.sv]
// Channel  | Ports                                            | Handshake
// ---------+--------------------------------------------------+-----------------------------
// request  | i_kind, i_item_value, i_position                 | taken when start && !busy
// result   | o_status, o_entry_count, o_out_value, o_out_valid| held to next request, o_done
//
// One request is taken per clock cycle; its result appears on the cycle after it is taken,
// marked by o_done. The figure is set by the row of cells, which shifts or holds in the
// same cycle the request is decoded. busy stays low: a request never has to wait.
// Reset (synchronous, active low) empties the list and clears o_done; the entry cells
// themselves are not cleared. The receiver cannot stall, so results are never held back.
module positional_list_store_top
    import pls_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_kind,
    input  logic [VALUE_W-1:0] i_item_value,
    input  logic [POS_W-1:0]   i_position,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [COUNT_W-1:0] o_entry_count,
    output logic [VALUE_W-1:0] o_out_value,
    output logic               o_out_valid
);

    // Controller decode and per-cell broadcast.
    t_cell_ctl          cell_ctl;
    logic               accept;
    logic [VALUE_W-1:0] tap_value;

    // Each cell sees its neighbors' values; the taps are OR-ed into one bus since at most
    // one cell drives a nonzero tap in a cycle.
    logic [VALUE_W-1:0] cell_value [CAPACITY];
    logic [VALUE_W-1:0] cell_tap   [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    pls_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_tap_value  (tap_value),
        .o_ctl        (cell_ctl),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_entry_count(o_entry_count),
        .o_out_value  (o_out_value),
        .o_out_valid  (o_out_valid)
    );

    // The row of cells. The first cell never takes from below and the last one takes
    // zero from above, which only lands in a slot beyond the new count.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] left;
        logic [VALUE_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = i_item_value;
        end else begin : g_mid_left
            assign left = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_right
            assign right = cell_value[g+1];
        end

        pls_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_new_value(i_item_value),
            .i_left     (left),
            .i_right    (right),
            .o_value    (cell_value[g]),
            .o_tap      (cell_tap[g])
        );
    end

    // Collect the selected cell's value for reads and deletes.
    always_comb begin
        tap_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            tap_value = tap_value | cell_tap[k];
        end
    end

endmodule
